[sv/uscdp_pkg.sv]
// Shared types and constants of the configuration descriptor parser.
package uscdp_pkg;

	localparam int MAX_INTERFACES_DEF  = 8;
	localparam int MAX_ALTSETTINGS_DEF = 4;
	localparam int MAX_ENDPOINTS_DEF   = 16;
	localparam int QUEUE_DEPTH_DEF     = 2;

	localparam int DESC_BYTES = 9;

	localparam logic [7:0] TYPE_CONFIG    = 8'h02;
	localparam logic [7:0] TYPE_INTERFACE = 8'h04;
	localparam logic [7:0] TYPE_ENDPOINT  = 8'h05;
	localparam logic [7:0] TYPE_SS_COMP   = 8'h30;

	localparam logic [3:0] COPY_FULL = 4'd9;
	localparam logic [3:0] COPY_COMP = 4'd6;

	typedef enum logic [2:0] {
		KIND_CONFIG    = 3'd0,
		KIND_INTERFACE = 3'd1,
		KIND_ENDPOINT  = 3'd2,
		KIND_COMPANION = 3'd3,
		KIND_STATUS    = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_TOO_SHORT    = 3'd1,
		ST_BAD_TYPE     = 3'd2,
		ST_SHORT_BUFFER = 3'd3,
		ST_BAD_LENGTH   = 3'd4,
		ST_TOO_MANY     = 3'd5,
		ST_MISMATCH     = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		PH_HEAD = 2'd0,
		PH_WALK = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	// one queued burst: a descriptor copy and/or the final status
	typedef struct packed {
		kind_t           kind;
		logic [2:0]      slot;
		logic [1:0]      alt;
		logic [3:0]      ep;
		logic [3:0]      count;
		logic            mk;
		logic [8:0][7:0] bytes;
		logic            has_status;
		status_t         status;
		logic [3:0]      total;
	} job_t;

endpackage

[sv/usb_config_descriptor_parser_unit.sv]
// Top level of the USB configuration descriptor parser.
// The unit takes a received configuration descriptor one byte per request and
// walks it: header checks (type, wTotalLength against the buffer, bLength),
// interface numbers mapped to dense slots, alternate settings counted per slot
// and endpoints per alternate setting. When a descriptor ends, its stored bytes
// (at most nine, six for a companion) leave as records tagged with slot,
// alternate setting, endpoint and offset; the final byte adds a status record,
// and on a nonzero status the consumer drops every record of that buffer.
// Timing: the byte parser takes one byte per cycle while the two-entry job
// queue has room; the record emitter sends one record per cycle while out_ready
// is high, so a byte that ends a descriptor yields up to ten records (nine bytes plus status).
// Sustained throughput is one byte per cycle while out_ready is high, set by the
// emitter drain rate over the bursts; no clearing pass follows reset.
module usb_config_descriptor_parser_unit #(
	parameter int MAX_INTERFACES  = uscdp_pkg::MAX_INTERFACES_DEF,
	parameter int MAX_ALTSETTINGS = uscdp_pkg::MAX_ALTSETTINGS_DEF,
	parameter int MAX_ENDPOINTS   = uscdp_pkg::MAX_ENDPOINTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic [15:0] buffer_length,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  record_kind,
	output logic [2:0]  interface_slot,
	output logic [1:0]  alt_slot,
	output logic [3:0]  endpoint_slot,
	output logic [3:0]  byte_offset,
	output logic [7:0]  byte_value,
	output logic        make_active,
	output logic [2:0]  parse_status,
	output logic [3:0]  interface_total,
	output logic        last_result
);
	import uscdp_pkg::*;

	logic push, pop, full, head_valid;
	job_t push_job, head_job;

	// front: one request per cycle while the queue has room, builds a job per copied descriptor / last byte
	uscdp_front #(
		.MAX_INTERFACES (MAX_INTERFACES),
		.MAX_ALTSETTINGS(MAX_ALTSETTINGS),
		.MAX_ENDPOINTS  (MAX_ENDPOINTS)
	) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .data_byte, .buffer_length,
		.last_byte, .full, .push, .push_job
	);

	// decouples parsing from record drain
	uscdp_fifo #(.DEPTH(QUEUE_DEPTH_DEF)) u_fifo (
		.clk, .arst_n, .push, .push_job, .full, .pop, .head_job, .head_valid
	);

	// back: one record per cycle while out_ready is high
	uscdp_back u_back (
		.clk, .arst_n, .head_job, .head_valid, .pop, .out_valid, .out_ready,
		.record_kind, .interface_slot, .alt_slot, .endpoint_slot, .byte_offset,
		.byte_value, .make_active, .parse_status, .interface_total, .last_result
	);

endmodule

[sv/uscdp_fifo.sv]
// Short job queue between the byte parser and the record emitter.
module uscdp_fifo #(
	parameter int DEPTH = uscdp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  uscdp_pkg::job_t push_job,
	output logic            full,
	input  logic            pop,
	output uscdp_pkg::job_t head_job,
	output logic            head_valid
);
	import uscdp_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

[sv/uscdp_front.sv]
// Byte parser: header checks, descriptor walk, interface mapping, job build.
module uscdp_front #(
	parameter int MAX_INTERFACES  = uscdp_pkg::MAX_INTERFACES_DEF,
	parameter int MAX_ALTSETTINGS = uscdp_pkg::MAX_ALTSETTINGS_DEF,
	parameter int MAX_ENDPOINTS   = uscdp_pkg::MAX_ENDPOINTS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      data_byte,
	input  logic [15:0]     buffer_length,
	input  logic            last_byte,
	input  logic            full,
	output logic            push,
	output uscdp_pkg::job_t push_job
);
	import uscdp_pkg::*;

	localparam int SW  = (MAX_INTERFACES > 1) ? $clog2(MAX_INTERFACES) : 1;
	localparam int UW  = $clog2(MAX_INTERFACES + 1);
	localparam int AW  = (MAX_ALTSETTINGS > 1) ? $clog2(MAX_ALTSETTINGS) : 1;
	localparam int ACW = $clog2(MAX_ALTSETTINGS + 1);
	localparam int EW  = $clog2(MAX_ENDPOINTS + 1);

	logic                accept;
	logic [15:0]         pos_q, pos_d;
	logic [7:0]          cfg_len_q, cfg_len_d, cfg_type_q, cfg_type_d;
	logic [15:0]         tot_len_q, tot_len_d;
	logic [7:0]          decl_q, decl_d;
	logic [15:0]         dstart_q, dstart_d;
	logic [7:0]          dlen_q, dlen_d, dtype_q, dtype_d;
	logic [8:0][7:0]     dbytes_q, dbytes_d;
	logic                map_valid_q [MAX_INTERFACES];
	logic                map_valid_d [MAX_INTERFACES];
	logic [SW-1:0]       map_slot_q  [MAX_INTERFACES];
	logic [SW-1:0]       map_slot_d  [MAX_INTERFACES];
	logic [ACW-1:0]      alt_cnt_q   [MAX_INTERFACES];
	logic [ACW-1:0]      alt_cnt_d   [MAX_INTERFACES];
	logic                active_q    [MAX_INTERFACES];
	logic                active_d    [MAX_INTERFACES];
	logic [UW-1:0]       uniq_q, uniq_d;
	logic [SW-1:0]       cur_slot_q, cur_slot_d;
	logic [AW-1:0]       cur_alt_q, cur_alt_d;
	logic                alt_valid_q, alt_valid_d;
	logic [EW-1:0]       ep_cnt_q, ep_cnt_d;
	phase_t              phase_q, phase_d;
	logic                too_many_q, too_many_d;

	// copy request towards the job builder
	logic                cp_en, cp_mk;
	kind_t               cp_kind;
	logic [SW-1:0]       cp_slot;
	logic [AW-1:0]       cp_alt;
	logic [EW-1:0]       cp_ep;
	logic [7:0]          cp_len;
	logic [3:0]          cp_cap;
	logic [8:0][7:0]     cp_bytes;
	status_t             st;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		logic [15:0]    off;
		logic [7:0]     endoff;
		logic [16:0]    nxt;
		logic           fin;
		logic [7:0]     ifn, alts;
		logic [SW-1:0]  ii, slot;
		logic           newm, act;
		logic [ACW-1:0] ac;
		logic [16:0]    cnt, len17;

		pos_d = pos_q; cfg_len_d = cfg_len_q; cfg_type_d = cfg_type_q;
		tot_len_d = tot_len_q; decl_d = decl_q; dstart_d = dstart_q;
		dlen_d = dlen_q; dtype_d = dtype_q; dbytes_d = dbytes_q;
		map_valid_d = map_valid_q; map_slot_d = map_slot_q;
		alt_cnt_d = alt_cnt_q; active_d = active_q; uniq_d = uniq_q;
		cur_slot_d = cur_slot_q; cur_alt_d = cur_alt_q; alt_valid_d = alt_valid_q;
		ep_cnt_d = ep_cnt_q; phase_d = phase_q; too_many_d = too_many_q;
		cp_en = 1'b0; cp_mk = 1'b0; cp_kind = KIND_CONFIG; cp_slot = '0; cp_alt = '0;
		cp_ep = '0; cp_len = '0; cp_cap = COPY_FULL;
		off = '0; endoff = '0; nxt = '0; fin = 1'b0; ifn = '0; alts = '0;
		ii = '0; slot = '0; newm = 1'b0; act = 1'b0; ac = '0;
		cnt = '0; len17 = '0; st = ST_OK;

		if (pos_q != 16'hFFFF) pos_d = pos_q + 16'd1;

		if (accept && pos_q < buffer_length) begin
			case (pos_q)
				16'd0:   cfg_len_d = data_byte;
				16'd1:   cfg_type_d = data_byte;
				16'd2:   tot_len_d[7:0] = data_byte;
				16'd3:   tot_len_d[15:8] = data_byte;
				16'd4:   decl_d = data_byte;
				default: ;
			endcase
			case (phase_q)
				PH_HEAD: begin
					if (pos_q < 16'd9) dbytes_d[pos_q[3:0]] = data_byte;
					if (pos_q == 16'd3 && (cfg_type_d != TYPE_CONFIG ||
					    buffer_length < tot_len_d || cfg_len_d < 8'd4 ||
					    {8'd0, cfg_len_d} > tot_len_d))
						phase_d = PH_DONE;
					if (phase_d == PH_HEAD && pos_q >= 16'd3 &&
					    ({1'b0, pos_q} + 17'd1 == {9'd0, cfg_len_d})) begin
						cp_en   = 1'b1;
						cp_kind = KIND_CONFIG;
						cp_len  = cfg_len_d;
						if ({10'd0, cfg_len_d} + 18'd2 > {2'd0, tot_len_d})
							phase_d = PH_DONE;
						else begin
							dstart_d = {8'd0, cfg_len_d};
							phase_d  = PH_WALK;
						end
					end
				end
				PH_WALK: begin
					if (pos_q >= dstart_q) begin
						off = pos_q - dstart_q;
						if (off == 16'd0) begin
							dlen_d = data_byte;
							if (data_byte == 8'd0 ||
							    {2'd0, dstart_q} + {10'd0, data_byte} > {2'd0, tot_len_d})
								phase_d = PH_DONE;
							else
								dbytes_d[0] = data_byte;
						end else begin
							if (off == 16'd1) dtype_d = data_byte;
							if (off < 16'd9 && off < {8'd0, dlen_q})
								dbytes_d[off[3:0]] = data_byte;
							endoff = (dlen_q > 8'd1) ? dlen_q - 8'd1 : 8'd1;
							fin = (off == {8'd0, endoff});
						end
					end
				end
				default: ;
			endcase
		end

		// bytes of the descriptor being copied, before the next one may reuse slot 0
		cp_bytes = dbytes_d;

		// end of an accepted descriptor
		if (fin) begin
			if (dtype_d == TYPE_INTERFACE) begin
				ifn  = (dlen_q > 8'd2) ? dbytes_d[2] : 8'd0;
				alts = (dlen_q > 8'd3) ? dbytes_d[3] : 8'd0;
				if (ifn >= MAX_INTERFACES) alt_valid_d = 1'b0;
				else begin
					ii   = ifn[SW-1:0];
					newm = !map_valid_q[ii];
					if (newm && uniq_q >= MAX_INTERFACES) begin
						too_many_d = 1'b1;
						phase_d    = PH_DONE;
					end else begin
						slot = newm ? uniq_q[SW-1:0] : map_slot_q[ii];
						ac   = newm ? '0 : alt_cnt_q[slot];
						act  = newm ? 1'b0 : active_q[slot];
						if (newm) begin
							map_valid_d[ii] = 1'b1;
							map_slot_d[ii]  = slot;
							uniq_d          = uniq_q + 1'b1;
							alt_cnt_d[slot] = '0;
							active_d[slot]  = 1'b0;
						end
						cur_slot_d = slot;
						if (ac >= MAX_ALTSETTINGS) alt_valid_d = 1'b0;
						else begin
							alt_cnt_d[slot] = ac + 1'b1;
							cur_alt_d       = ac[AW-1:0];
							alt_valid_d     = 1'b1;
							ep_cnt_d        = '0;
							cp_mk           = !act || alts == 8'd0;
							if (cp_mk) active_d[slot] = 1'b1;
							cp_en   = 1'b1;
							cp_kind = KIND_INTERFACE;
							cp_slot = slot;
							cp_alt  = ac[AW-1:0];
							cp_len  = dlen_q;
						end
					end
				end
			end else if (dtype_d == TYPE_ENDPOINT) begin
				if (alt_valid_q && ep_cnt_q < MAX_ENDPOINTS) begin
					cp_en    = 1'b1;
					cp_kind  = KIND_ENDPOINT;
					cp_slot  = cur_slot_q;
					cp_alt   = cur_alt_q;
					cp_ep    = ep_cnt_q;
					cp_len   = dlen_q;
					ep_cnt_d = ep_cnt_q + 1'b1;
				end
			end else if (dtype_d == TYPE_SS_COMP) begin
				if (alt_valid_q && ep_cnt_q != '0) begin
					cp_en   = 1'b1;
					cp_kind = KIND_COMPANION;
					cp_slot = cur_slot_q;
					cp_alt  = cur_alt_q;
					cp_ep   = ep_cnt_q - 1'b1;
					cp_len  = dlen_q;
					cp_cap  = COPY_COMP;
				end
			end
			// step to the next descriptor; a one-byte descriptor hands its
			// last byte over as the next one's bLength
			if (phase_d == PH_WALK) begin
				nxt = {1'b0, dstart_q} + {9'd0, dlen_q};
				if ({1'b0, nxt} + 18'd2 > {2'd0, tot_len_d}) phase_d = PH_DONE;
				else begin
					dstart_d = nxt[15:0];
					if (nxt == {1'b0, pos_q}) begin
						dlen_d = data_byte;
						if (data_byte == 8'd0 ||
						    {1'b0, nxt} + {10'd0, data_byte} > {2'd0, tot_len_d})
							phase_d = PH_DONE;
						else
							dbytes_d[0] = data_byte;
					end
				end
			end
		end

		// final status, on post-update state
		cnt   = {1'b0, pos_q} + 17'd1;
		len17 = ({1'b0, buffer_length} < cnt) ? {1'b0, buffer_length} : cnt;
		if (len17 < 17'd2)                                    st = ST_TOO_SHORT;
		else if (cfg_type_d != TYPE_CONFIG)                   st = ST_BAD_TYPE;
		else if (len17 < {1'b0, tot_len_d})                   st = ST_SHORT_BUFFER;
		else if (cfg_len_d < 8'd4 || {8'd0, cfg_len_d} > tot_len_d) st = ST_BAD_LENGTH;
		else if (too_many_d)                                  st = ST_TOO_MANY;
		else if ({{(8-UW){1'b0}}, uniq_d} != decl_d)          st = ST_MISMATCH;
		else                                                  st = ST_OK;
	end

	// job assembly
	always_comb begin
		logic [31:0] slot32, alt32, ep32, tot32;
		slot32 = 32'(cp_slot);
		alt32  = 32'(cp_alt);
		ep32   = 32'(cp_ep);
		tot32  = 32'(uniq_d);
		push_job            = '0;
		push_job.kind       = cp_kind;
		push_job.slot       = slot32[2:0];
		push_job.alt        = alt32[1:0];
		push_job.ep         = ep32[3:0];
		push_job.count      = !cp_en ? 4'd0 :
		                      ({4'd0, cp_cap} > cp_len) ? cp_len[3:0] : cp_cap;
		push_job.mk         = cp_mk;
		push_job.bytes      = cp_bytes;
		push_job.has_status = last_byte;
		push_job.status     = st;
		push_job.total      = tot32[3:0];
		push                = accept && (cp_en || last_byte);
	end

	always_ff @(posedge clk) begin
		if (accept) dbytes_q <= dbytes_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; cfg_len_q <= '0; cfg_type_q <= '0; tot_len_q <= '0;
			decl_q <= '0; dstart_q <= '0; dlen_q <= '0; dtype_q <= '0;
			uniq_q <= '0; cur_slot_q <= '0; cur_alt_q <= '0; alt_valid_q <= 1'b0;
			ep_cnt_q <= '0; phase_q <= PH_HEAD; too_many_q <= 1'b0;
			for (int i = 0; i < MAX_INTERFACES; i++) begin
				map_valid_q[i] <= 1'b0; map_slot_q[i] <= '0;
				alt_cnt_q[i] <= '0; active_q[i] <= 1'b0;
			end
		end else if (accept) begin
			if (last_byte) begin
				pos_q <= '0; cfg_len_q <= '0; cfg_type_q <= '0; tot_len_q <= '0;
				decl_q <= '0; dstart_q <= '0; dlen_q <= '0; dtype_q <= '0;
				uniq_q <= '0; cur_slot_q <= '0; cur_alt_q <= '0; alt_valid_q <= 1'b0;
				ep_cnt_q <= '0; phase_q <= PH_HEAD; too_many_q <= 1'b0;
				for (int i = 0; i < MAX_INTERFACES; i++) begin
					map_valid_q[i] <= 1'b0; map_slot_q[i] <= '0;
					alt_cnt_q[i] <= '0; active_q[i] <= 1'b0;
				end
			end else begin
				pos_q <= pos_d; cfg_len_q <= cfg_len_d; cfg_type_q <= cfg_type_d;
				tot_len_q <= tot_len_d; decl_q <= decl_d; dstart_q <= dstart_d;
				dlen_q <= dlen_d; dtype_q <= dtype_d; uniq_q <= uniq_d;
				cur_slot_q <= cur_slot_d; cur_alt_q <= cur_alt_d;
				alt_valid_q <= alt_valid_d; ep_cnt_q <= ep_cnt_d;
				phase_q <= phase_d; too_many_q <= too_many_d;
				map_valid_q <= map_valid_d; map_slot_q <= map_slot_d;
				alt_cnt_q <= alt_cnt_d; active_q <= active_d;
			end
		end
	end

endmodule

[sv/uscdp_back.sv]
// Record emitter: drains one queued job as byte records and, for the last byte, a status record.
module uscdp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  uscdp_pkg::job_t head_job,
	input  logic            head_valid,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [2:0]      record_kind,
	output logic [2:0]      interface_slot,
	output logic [1:0]      alt_slot,
	output logic [3:0]      endpoint_slot,
	output logic [3:0]      byte_offset,
	output logic [7:0]      byte_value,
	output logic            make_active,
	output logic [2:0]      parse_status,
	output logic [3:0]      interface_total,
	output logic            last_result
);
	import uscdp_pkg::*;

	logic [3:0] idx_q;
	logic [4:0] nrec;
	logic       is_stat, final_rec;

	assign nrec      = {1'b0, head_job.count} + {4'd0, head_job.has_status};
	assign final_rec = ({1'b0, idx_q} + 5'd1 == nrec);
	assign is_stat   = (idx_q == head_job.count);
	assign out_valid = head_valid;
	assign pop       = out_valid && out_ready && final_rec;

	always_comb begin
		record_kind     = is_stat ? KIND_STATUS : head_job.kind;
		interface_slot  = is_stat ? 3'd0 : head_job.slot;
		alt_slot        = is_stat ? 2'd0 : head_job.alt;
		endpoint_slot   = is_stat ? 4'd0 : head_job.ep;
		byte_offset     = is_stat ? 4'd0 : idx_q;
		byte_value      = (is_stat || idx_q >= 4'(DESC_BYTES)) ? 8'd0 :
		                  head_job.bytes[idx_q];
		make_active     = is_stat ? 1'b0 : head_job.mk;
		parse_status    = is_stat ? head_job.status : ST_OK;
		interface_total = is_stat ? head_job.total : 4'd0;
		last_result     = final_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) idx_q <= '0;
		else if (out_valid && out_ready) idx_q <= final_rec ? 4'd0 : idx_q + 4'd1;
	end

endmodule

[sv/uscdp_checker.sv]
// Port-level checks for the descriptor parser, bound to the top level.
module uscdp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  record_kind,
	input logic [2:0]  interface_slot,
	input logic [1:0]  alt_slot,
	input logic [3:0]  endpoint_slot,
	input logic [3:0]  byte_offset,
	input logic        make_active,
	input logic [2:0]  parse_status,
	input logic [3:0]  interface_total,
	input logic        last_result
);
	import uscdp_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(record_kind) &&
		$stable(byte_offset) && $stable(last_result))
		else $error("record changed while stalled");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind == KIND_STATUS |-> last_result)
		else $error("status record not last");

	a_byte_rec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind != KIND_STATUS |->
		parse_status == ST_OK && interface_total == 4'd0 && byte_offset <= 4'd8)
		else $error("byte record fields out of place");

	a_cfg_rec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind == KIND_CONFIG |->
		interface_slot == 3'd0 && alt_slot == 2'd0 && endpoint_slot == 4'd0 &&
		!make_active)
		else $error("config record carries a slot");

endmodule

bind usb_config_descriptor_parser_unit uscdp_checker u_chk (.*);
